FILE: hdl/i2cms_pkg.sv
package i2cms_pkg;

    localparam int PhaseW = 4;

    localparam logic [PhaseW-1:0] PhIdle = 4'd0;
    localparam logic [PhaseW-1:0] PhSt1  = 4'd1;
    localparam logic [PhaseW-1:0] PhSt2  = 4'd2;
    localparam logic [PhaseW-1:0] PhSp1  = 4'd3;
    localparam logic [PhaseW-1:0] PhSp2  = 4'd4;
    localparam logic [PhaseW-1:0] PhWrHi = 4'd5;
    localparam logic [PhaseW-1:0] PhWrLo = 4'd6;
    localparam logic [PhaseW-1:0] PhRdHi = 4'd7;
    localparam logic [PhaseW-1:0] PhRdLo = 4'd8;
    localparam logic [PhaseW-1:0] PhAkHi = 4'd9;
    localparam logic [PhaseW-1:0] PhAkLo = 4'd10;
    localparam logic [PhaseW-1:0] PhWa   = 4'd11;

    localparam logic [2:0] ReqTick  = 3'd0;
    localparam logic [2:0] ReqStart = 3'd1;
    localparam logic [2:0] ReqStop  = 3'd2;
    localparam logic [2:0] ReqWrite = 3'd3;
    localparam logic [2:0] ReqRead  = 3'd4;
    localparam logic [2:0] ReqWait  = 3'd5;

    localparam logic [7:0] AckTimeoutReset = 8'd100;

    typedef struct packed {
        logic [PhaseW-1:0] phase;
        logic [3:0]        bit_index;
        logic [7:0]        shift_data;
        logic [7:0]        poll_count;
        logic              ack_choice;
        logic              scl;
        logic              sda;
        logic              drv;
        logic              fail;
        logic [7:0]        rx_hold;
    } seq_state_t;

    localparam seq_state_t StateReset = '{
        phase:      PhIdle,
        bit_index:  4'd0,
        shift_data: 8'd0,
        poll_count: 8'd0,
        ack_choice: 1'b0,
        scl:        1'b1,
        sda:        1'b1,
        drv:        1'b1,
        fail:       1'b0,
        rx_hold:    8'd0
    };

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } seq_req_t;

endpackage

FILE: hdl/i2c_master_bit_sequencer_core.sv
// Bit-level I2C master sequencer. Issue start, stop, write, read or wait-ack
// while idle, then one tick transfer per bus phase carrying the sampled SDA.
// Every input transfer gives exactly one result transfer with the pin levels
// and status. One transfer is taken every clock unless out_stall holds a
// result; each result appears in the next clock from the output register,
// set by the single phase-update step between the sequence state and that
// register. ack_timeout may be written only while no result is pending.
module i2c_master_bit_sequencer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] req_type,
    input  logic [7:0] tx_byte,
    input  logic       send_ack,
    input  logic       sda_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       scl_level,
    output logic       sda_level,
    output logic       sda_drive,
    output logic       busy_res,
    output logic       done_res,
    output logic [7:0] rx_byte,
    output logic       ack_failed
);

    i2cms_pkg::seq_state_t state_reg;
    i2cms_pkg::seq_state_t state_next;
    i2cms_pkg::seq_req_t   req;
    logic [7:0]            ack_timeout_reg;
    logic                  done_next;
    logic                  in_accept;
    logic                  out_valid_reg;
    logic                  scl_reg;
    logic                  sda_reg;
    logic                  drv_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [7:0]            rx_reg;
    logic                  fail_reg;

    assign req = '{req_type: req_type, tx_byte: tx_byte, send_ack: send_ack,
                   sda_in: sda_in};

    i2cms_step u_step (
        .state       (state_reg),
        .req         (req),
        .ack_timeout (ack_timeout_reg),
        .state_next  (state_next),
        .done        (done_next)
    );

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_timeout_reg <= i2cms_pkg::AckTimeoutReset;
        end
        else if (cfg_wr_en)
        begin
            ack_timeout_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= i2cms_pkg::StateReset;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                state_reg <= state_next;
            end
            if (in_accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            scl_reg  <= state_next.scl;
            sda_reg  <= state_next.drv ? state_next.sda : 1'b1;
            drv_reg  <= state_next.drv;
            busy_reg <= state_next.phase != i2cms_pkg::PhIdle;
            done_reg <= done_next;
            rx_reg   <= state_next.rx_hold;
            fail_reg <= state_next.fail;
        end
    end

    assign out_valid  = out_valid_reg;
    assign scl_level  = scl_reg;
    assign sda_level  = sda_reg;
    assign sda_drive  = drv_reg;
    assign busy_res   = busy_reg;
    assign done_res   = done_reg;
    assign rx_byte    = rx_reg;
    assign ack_failed = fail_reg;

    a_released_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sda_drive || sda_level))
        else $error("released SDA not reported high");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> !busy_res)
        else $error("done with sequence still busy");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid)
        else $error("accepted transfer produced no result");

    a_wait_clears_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && state_reg.phase == i2cms_pkg::PhIdle
            && req_type == i2cms_pkg::ReqWait) |=> (!ack_failed && busy_res))
        else $error("wait-ack start did not clear failure");

endmodule

FILE: hdl/i2cms_step.sv
module i2cms_step (
    input  i2cms_pkg::seq_state_t state,
    input  i2cms_pkg::seq_req_t   req,
    input  logic [7:0]            ack_timeout,
    output i2cms_pkg::seq_state_t state_next,
    output logic                  done
);

    logic [3:0] bit_inc;

    assign bit_inc = state.bit_index + 4'd1;

    always_comb
    begin
        state_next = state;
        done       = 1'b0;
        if (state.phase == i2cms_pkg::PhIdle)
        begin
            unique case (req.req_type)
                i2cms_pkg::ReqStart:
                begin
                    state_next.scl   = 1'b1;
                    state_next.sda   = 1'b1;
                    state_next.drv   = 1'b1;
                    state_next.phase = i2cms_pkg::PhSt1;
                end
                i2cms_pkg::ReqStop:
                begin
                    state_next.scl   = 1'b0;
                    state_next.sda   = 1'b0;
                    state_next.drv   = 1'b1;
                    state_next.phase = i2cms_pkg::PhSp1;
                end
                i2cms_pkg::ReqWrite:
                begin
                    state_next.scl        = 1'b0;
                    state_next.drv        = 1'b1;
                    state_next.shift_data = req.tx_byte;
                    state_next.bit_index  = 4'd0;
                    state_next.phase      = i2cms_pkg::PhWrHi;
                end
                i2cms_pkg::ReqRead:
                begin
                    state_next.scl        = 1'b0;
                    state_next.sda        = 1'b1;
                    state_next.drv        = 1'b0;
                    state_next.shift_data = 8'd0;
                    state_next.bit_index  = 4'd0;
                    state_next.ack_choice = req.send_ack;
                    state_next.phase      = i2cms_pkg::PhRdHi;
                end
                i2cms_pkg::ReqWait:
                begin
                    state_next.scl        = 1'b1;
                    state_next.sda        = 1'b1;
                    state_next.drv        = 1'b0;
                    state_next.poll_count = 8'd0;
                    state_next.fail       = 1'b0;
                    state_next.phase      = i2cms_pkg::PhWa;
                end
                default:
                begin
                end
            endcase
        end
        else if (req.req_type == i2cms_pkg::ReqTick)
        begin
            unique case (state.phase)
                i2cms_pkg::PhSt1:
                begin
                    state_next.scl   = 1'b1;
                    state_next.sda   = 1'b0;
                    state_next.drv   = 1'b1;
                    state_next.phase = i2cms_pkg::PhSt2;
                end
                i2cms_pkg::PhSt2:
                begin
                    state_next.scl   = 1'b0;
                    state_next.sda   = 1'b0;
                    state_next.drv   = 1'b1;
                    state_next.phase = i2cms_pkg::PhIdle;
                    done             = 1'b1;
                end
                i2cms_pkg::PhSp1:
                begin
                    state_next.scl   = 1'b1;
                    state_next.sda   = 1'b0;
                    state_next.drv   = 1'b1;
                    state_next.phase = i2cms_pkg::PhSp2;
                end
                i2cms_pkg::PhSp2:
                begin
                    state_next.scl   = 1'b1;
                    state_next.sda   = 1'b1;
                    state_next.drv   = 1'b1;
                    state_next.phase = i2cms_pkg::PhIdle;
                    done             = 1'b1;
                end
                i2cms_pkg::PhWrHi:
                begin
                    state_next.scl        = 1'b1;
                    state_next.sda        = state.shift_data[7];
                    state_next.drv        = 1'b1;
                    state_next.shift_data = {state.shift_data[6:0], 1'b0};
                    state_next.phase      = i2cms_pkg::PhWrLo;
                end
                i2cms_pkg::PhWrLo:
                begin
                    state_next.scl       = 1'b0;
                    state_next.drv       = 1'b1;
                    state_next.bit_index = bit_inc;
                    if (bit_inc[3])
                    begin
                        state_next.phase = i2cms_pkg::PhIdle;
                        done             = 1'b1;
                    end
                    else
                    begin
                        state_next.phase = i2cms_pkg::PhWrHi;
                    end
                end
                i2cms_pkg::PhRdHi:
                begin
                    state_next.scl   = 1'b1;
                    state_next.sda   = 1'b1;
                    state_next.drv   = 1'b0;
                    state_next.phase = i2cms_pkg::PhRdLo;
                end
                i2cms_pkg::PhRdLo:
                begin
                    state_next.shift_data = {state.shift_data[6:0], req.sda_in};
                    state_next.bit_index  = bit_inc;
                    state_next.scl        = 1'b0;
                    if (bit_inc[3])
                    begin
                        state_next.sda   = ~state.ack_choice;
                        state_next.drv   = 1'b1;
                        state_next.phase = i2cms_pkg::PhAkHi;
                    end
                    else
                    begin
                        state_next.sda   = 1'b1;
                        state_next.drv   = 1'b0;
                        state_next.phase = i2cms_pkg::PhRdHi;
                    end
                end
                i2cms_pkg::PhAkHi:
                begin
                    state_next.scl   = 1'b1;
                    state_next.drv   = 1'b1;
                    state_next.phase = i2cms_pkg::PhAkLo;
                end
                i2cms_pkg::PhAkLo:
                begin
                    state_next.scl     = 1'b0;
                    state_next.drv     = 1'b1;
                    state_next.rx_hold = state.shift_data;
                    state_next.phase   = i2cms_pkg::PhIdle;
                    done               = 1'b1;
                end
                i2cms_pkg::PhWa:
                begin
                    if (!req.sda_in)
                    begin
                        state_next.scl   = 1'b0;
                        state_next.sda   = 1'b1;
                        state_next.drv   = 1'b0;
                        state_next.phase = i2cms_pkg::PhIdle;
                        done             = 1'b1;
                    end
                    else if (state.poll_count >= ack_timeout)
                    begin
                        state_next.fail  = 1'b1;
                        state_next.scl   = 1'b0;
                        state_next.sda   = 1'b0;
                        state_next.drv   = 1'b1;
                        state_next.phase = i2cms_pkg::PhSp1;
                    end
                    else
                    begin
                        state_next.poll_count = state.poll_count + 8'd1;
                    end
                end
                default:
                begin
                    state_next.phase = i2cms_pkg::PhIdle;
                end
            endcase
        end
    end

endmodule

FILE: sim/tb_i2c_master_bit_sequencer_core.sv
module tb_i2c_master_bit_sequencer_core;

    localparam logic [2:0] ReqSpare6 = 3'd6;
    localparam logic [2:0] ReqSpare7 = 3'd7;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       drv;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       fail;
    } bus_result_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
    logic       out_valid;
    logic       out_stall;
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;

    // predicted sequencer state
    logic [i2cms_pkg::PhaseW-1:0] bus_phase;
    logic [3:0]                   bit_cnt;
    logic [7:0]                   shift_reg;
    logic [7:0]                   poll_cnt;
    logic                         ack_sel;
    logic                         pin_scl;
    logic                         pin_sda;
    logic                         pin_drv;
    logic                         nack_fail;
    logic [7:0]                   rx_last;
    logic [7:0]                   ack_limit;

    bus_result_t bus_expect_q[$];
    int unsigned mismatches    = 0;
    int unsigned results_seen  = 0;
    int unsigned items_sent    = 0;
    int unsigned timeouts_seen = 0;
    bit          gaps_on       = 1'b1;
    bit          tail_quiet    = 1'b0;
    bit          hold_req      = 1'b0;
    logic [7:0]  rand_limit;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    i2c_master_bit_sequencer_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .tx_byte     (tx_byte),
        .send_ack    (send_ack),
        .sda_in      (sda_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .scl_level   (scl_level),
        .sda_level   (sda_level),
        .sda_drive   (sda_drive),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .rx_byte     (rx_byte),
        .ack_failed  (ack_failed)
    );

    function automatic void set_pins(input logic s, input logic d, input logic v);
        pin_scl = s;
        pin_sda = d;
        pin_drv = v;
    endfunction

    function automatic bus_result_t predict_bus(input logic [2:0] req, input logic [7:0] txb,
                                                input logic sack, input logic sda);
        bus_result_t r;
        logic        fin;
        fin = 1'b0;
        if (bus_phase == i2cms_pkg::PhIdle)
        begin
            case (req)
                i2cms_pkg::ReqStart:
                begin
                    set_pins(1'b1, 1'b1, 1'b1);
                    bus_phase = i2cms_pkg::PhSt1;
                end
                i2cms_pkg::ReqStop:
                begin
                    set_pins(1'b0, 1'b0, 1'b1);
                    bus_phase = i2cms_pkg::PhSp1;
                end
                i2cms_pkg::ReqWrite:
                begin
                    set_pins(1'b0, pin_sda, 1'b1);
                    shift_reg = txb;
                    bit_cnt   = 4'd0;
                    bus_phase = i2cms_pkg::PhWrHi;
                end
                i2cms_pkg::ReqRead:
                begin
                    set_pins(1'b0, 1'b1, 1'b0);
                    shift_reg = 8'd0;
                    bit_cnt   = 4'd0;
                    ack_sel   = sack;
                    bus_phase = i2cms_pkg::PhRdHi;
                end
                i2cms_pkg::ReqWait:
                begin
                    set_pins(1'b1, 1'b1, 1'b0);
                    poll_cnt  = 8'd0;
                    nack_fail = 1'b0;
                    bus_phase = i2cms_pkg::PhWa;
                end
                default: ;
            endcase
        end
        else if (req == i2cms_pkg::ReqTick)
        begin
            case (bus_phase)
                i2cms_pkg::PhSt1:
                begin
                    set_pins(1'b1, 1'b0, 1'b1);
                    bus_phase = i2cms_pkg::PhSt2;
                end
                i2cms_pkg::PhSt2:
                begin
                    set_pins(1'b0, 1'b0, 1'b1);
                    bus_phase = i2cms_pkg::PhIdle;
                    fin = 1'b1;
                end
                i2cms_pkg::PhSp1:
                begin
                    set_pins(1'b1, 1'b0, 1'b1);
                    bus_phase = i2cms_pkg::PhSp2;
                end
                i2cms_pkg::PhSp2:
                begin
                    set_pins(1'b1, 1'b1, 1'b1);
                    bus_phase = i2cms_pkg::PhIdle;
                    fin = 1'b1;
                end
                i2cms_pkg::PhWrHi:
                begin
                    set_pins(1'b1, shift_reg[7], 1'b1);
                    shift_reg = {shift_reg[6:0], 1'b0};
                    bus_phase = i2cms_pkg::PhWrLo;
                end
                i2cms_pkg::PhWrLo:
                begin
                    set_pins(1'b0, pin_sda, 1'b1);
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= 4'd8)
                    begin
                        bus_phase = i2cms_pkg::PhIdle;
                        fin = 1'b1;
                    end
                    else
                    begin
                        bus_phase = i2cms_pkg::PhWrHi;
                    end
                end
                i2cms_pkg::PhRdHi:
                begin
                    set_pins(1'b1, 1'b1, 1'b0);
                    bus_phase = i2cms_pkg::PhRdLo;
                end
                i2cms_pkg::PhRdLo:
                begin
                    shift_reg = {shift_reg[6:0], sda};
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= 4'd8)
                    begin
                        set_pins(1'b0, ~ack_sel, 1'b1);
                        bus_phase = i2cms_pkg::PhAkHi;
                    end
                    else
                    begin
                        set_pins(1'b0, 1'b1, 1'b0);
                        bus_phase = i2cms_pkg::PhRdHi;
                    end
                end
                i2cms_pkg::PhAkHi:
                begin
                    set_pins(1'b1, pin_sda, 1'b1);
                    bus_phase = i2cms_pkg::PhAkLo;
                end
                i2cms_pkg::PhAkLo:
                begin
                    set_pins(1'b0, pin_sda, 1'b1);
                    rx_last   = shift_reg;
                    bus_phase = i2cms_pkg::PhIdle;
                    fin = 1'b1;
                end
                i2cms_pkg::PhWa:
                begin
                    if (!sda)
                    begin
                        set_pins(1'b0, 1'b1, 1'b0);
                        bus_phase = i2cms_pkg::PhIdle;
                        fin = 1'b1;
                    end
                    else if (poll_cnt >= ack_limit)
                    begin
                        // no acknowledge in time: fall into a stop
                        nack_fail = 1'b1;
                        set_pins(1'b0, 1'b0, 1'b1);
                        bus_phase = i2cms_pkg::PhSp1;
                        timeouts_seen++;
                    end
                    else
                    begin
                        poll_cnt = poll_cnt + 8'd1;
                    end
                end
                default: bus_phase = i2cms_pkg::PhIdle;
            endcase
        end
        r.scl  = pin_scl;
        r.sda  = pin_drv ? pin_sda : 1'b1;
        r.drv  = pin_drv;
        r.busy = (bus_phase != i2cms_pkg::PhIdle);
        r.done = fin;
        r.rx   = rx_last;
        r.fail = nack_fail;
        return r;
    endfunction

    task automatic log_mismatch(input string what, input bus_result_t want,
                                input bus_result_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%s at %0t: want scl=%b sda=%b drv=%b busy=%b done=%b rx=%02h fail=%b",
                     what, $time, want.scl, want.sda, want.drv, want.busy, want.done,
                     want.rx, want.fail);
            $display("    got scl=%b sda=%b drv=%b busy=%b done=%b rx=%02h fail=%b",
                     got.scl, got.sda, got.drv, got.busy, got.done, got.rx, got.fail);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        bus_result_t want;
        bus_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {scl_level, sda_level, sda_drive, busy_res, done_res, rx_byte, ack_failed};
            results_seen++;
            if (bus_expect_q.size() == 0)
            begin
                log_mismatch("unexpected result", '0, got);
            end
            else
            begin
                want = bus_expect_q.pop_front();
                if (got !== want)
                    log_mismatch("result mismatch", want, got);
            end
        end
    end

    initial
    begin : sink_stall
        int n;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (50) @(posedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (!tail_quiet && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 7);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(input logic [2:0] req, input logic [7:0] txb,
                             input logic sack, input logic sda);
        int gap;
        in_valid <= 1'b1;
        req_type <= req;
        tx_byte  <= txb;
        send_ack <= sack;
        sda_in   <= sda;
        do @(posedge clk); while (in_stall);
        bus_expect_q.push_back(predict_bus(req, txb, sack, sda));
        items_sent++;
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (bus_expect_q.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_timeout(input logic [7:0] v);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        ack_limit = v;
    endtask

    // one well-formed command, ticked through to completion with some noise
    task automatic run_sequence(input logic [2:0] cmd, input int low_odds, input bit stubborn);
        logic [7:0] txb;
        logic [2:0] req;
        logic       sda;
        case ($urandom_range(0, 3))
            0:       txb = 8'h00;
            1:       txb = 8'hFF;
            default: txb = 8'($urandom);
        endcase
        send_item(cmd, txb, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        while (bus_phase != i2cms_pkg::PhIdle)
        begin
            req = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(0, 7)) : i2cms_pkg::ReqTick;
            if (bus_phase == i2cms_pkg::PhWa)
                sda = stubborn ? 1'b1 : ($urandom_range(0, low_odds - 1) == 0 ? 1'b0 : 1'b1);
            else
                sda = 1'($urandom_range(0, 1));
            send_item(req, 8'($urandom), 1'($urandom_range(0, 1)), sda);
        end
    endtask

    task automatic test_sequences(input int unsigned n, input int low_odds);
        int unsigned first;
        logic [2:0]  req;
        first = items_sent;
        while (items_sent - first < n)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       req = i2cms_pkg::ReqTick;
                    1:       req = ReqSpare6;
                    default: req = ReqSpare7;
                endcase
                send_item(req, 8'($urandom), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end
            run_sequence(3'($urandom_range(i2cms_pkg::ReqWait, i2cms_pkg::ReqStart)),
                         low_odds, 1'b0);
        end
    endtask

    task automatic test_directed();
        send_item(i2cms_pkg::ReqTick,  8'h00, 1'b0, 1'b0);
        send_item(ReqSpare6,           8'hFF, 1'b1, 1'b1);
        send_item(ReqSpare7,           8'h00, 1'b0, 1'b1);
        send_item(i2cms_pkg::ReqStart, 8'hFF, 1'b1, 1'b0);
        send_item(i2cms_pkg::ReqWrite, 8'hFF, 1'b1, 1'b1);
        send_item(i2cms_pkg::ReqTick,  8'h00, 1'b0, 1'b0);
        send_item(ReqSpare7,           8'hFF, 1'b1, 1'b1);
        send_item(i2cms_pkg::ReqTick,  8'hFF, 1'b1, 1'b1);
        send_item(i2cms_pkg::ReqStop,  8'h00, 1'b0, 1'b0);
        send_item(i2cms_pkg::ReqTick,  8'h00, 1'b0, 1'b1);
        send_item(i2cms_pkg::ReqTick,  8'hFF, 1'b1, 1'b0);
        send_item(i2cms_pkg::ReqWait,  8'h00, 1'b1, 1'b1);
        send_item(i2cms_pkg::ReqTick,  8'h00, 1'b0, 1'b0);
        set_timeout(8'd0);
        send_item(i2cms_pkg::ReqWait,  8'hFF, 1'b0, 1'b0);
        send_item(i2cms_pkg::ReqTick,  8'h00, 1'b0, 1'b1);
        send_item(i2cms_pkg::ReqTick,  8'h00, 1'b0, 1'b1);
        send_item(i2cms_pkg::ReqTick,  8'h00, 1'b0, 1'b0);
        send_item(i2cms_pkg::ReqTick,  8'hFF, 1'b1, 1'b1);
        set_timeout(i2cms_pkg::AckTimeoutReset);
    endtask

    task automatic test_ack_timeout_limit();
        set_timeout(8'd255);
        run_sequence(i2cms_pkg::ReqWait, 4, 1'b1);
        test_sequences(60, 4);
    endtask

    task automatic test_backpressure();
        set_timeout(8'd5);
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        test_sequences(24, 3);
        drain_results();
        gaps_on = 1'b1;
        test_sequences(120, 3);
    endtask

    task automatic test_tail();
        rand_limit = 8'($urandom_range(1, 254));
        set_timeout(rand_limit);
        gaps_on    = 1'b0;
        tail_quiet = 1'b1;
        test_sequences(100, 4);
    endtask

    initial
    begin : stimulus
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 8'd0;
        in_valid    <= 1'b0;
        req_type    <= i2cms_pkg::ReqTick;
        tx_byte     <= 8'd0;
        send_ack    <= 1'b0;
        sda_in      <= 1'b0;
        bus_phase = i2cms_pkg::PhIdle;
        bit_cnt   = 4'd0;
        shift_reg = 8'd0;
        poll_cnt  = 8'd0;
        ack_sel   = 1'b0;
        set_pins(1'b1, 1'b1, 1'b1);
        nack_fail = 1'b0;
        rx_last   = 8'd0;
        ack_limit = i2cms_pkg::AckTimeoutReset;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_sequences(40, 6);
        set_timeout(8'd0);
        test_sequences(120, 2);
        test_ack_timeout_limit();
        test_backpressure();
        test_tail();

        drain_results();
        repeat (5) @(posedge clk);
        $display("%0d transfers in, %0d results checked, %0d acknowledge timeouts",
                 items_sent, results_seen, timeouts_seen);
        $display("limits 0, 5, 100, 255 and %0d; long output hold and quiet tail included",
                 rand_limit);
        if (mismatches == 0 && bus_expect_q.size() == 0)
            $display("i2c_master_bit_sequencer_core: match");
        else
            $display("i2c_master_bit_sequencer_core: mismatch");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("i2c_master_bit_sequencer_core: mismatch");
        $finish;
    end

endmodule
